### sv/tdpg_pkg.sv
`default_nettype none
package tdpg_pkg;

  localparam int VALUE_W  = 16;
  localparam int PRIME_W  = 9;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int BITCNT_W = $clog2(VALUE_W);

  localparam logic REQ_GENERATE = 1'b0;
  localparam logic REQ_TEST     = 1'b1;

  typedef struct packed {
    logic load;
    logic rd;
    logic sq_load;
    logic div_start;
    logic div_step;
    logic k_inc;
    logic cand_inc;
    logic emit;
    logic answer;
  } dp_cmd_t;

  typedef struct packed {
    logic is_test;
    logic below_two;
    logic k_at_fill;
    logic sq_gt;
    logic div_last;
    logic rem_zero;
    logic gen_last;
  } dp_status_t;

endpackage
`default_nettype wire

### sv/tdpg_ctrl.sv
`default_nettype none
module tdpg_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  output tdpg_pkg::dp_cmd_t    cmd,
  input  tdpg_pkg::dp_status_t status
);
  import tdpg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_COMPARE,
    ST_DIVIDE,
    ST_CHECK,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   answer;
  logic   answer_next;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    answer_next    = answer;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.answer     = answer;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (status.is_test && status.below_two) begin
          answer_next = 1'b0;
          state_next  = ST_EMIT;
        end else if (status.k_at_fill) begin
          answer_next = 1'b1;
          state_next  = ST_EMIT;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.sq_load = 1'b1;
        state_next  = ST_COMPARE;
      end
      ST_COMPARE: begin
        if (status.sq_gt) begin
          answer_next = 1'b1;
          state_next  = ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status.rem_zero) begin
          cmd.k_inc  = 1'b1;
          state_next = ST_READ;
        end else if (status.is_test) begin
          answer_next = 1'b0;
          state_next  = ST_EMIT;
        end else begin
          cmd.cand_inc = 1'b1;
          state_next   = ST_READ;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = (status.is_test || status.gen_last) ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      answer    <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      answer    <= answer_next;
    end
  end

endmodule
`default_nettype wire

### sv/tdpg_dp.sv
`default_nettype none
module tdpg_dp #(
  parameter int MAX_PRIMES = 64
) (
  input  wire                                clk,
  input  wire                                rst,
  input  tdpg_pkg::dp_cmd_t                  cmd,
  output tdpg_pkg::dp_status_t               status,
  input  wire                                req_type,
  input  wire [tdpg_pkg::COUNT_W-1:0]        prime_count,
  input  wire [tdpg_pkg::VALUE_W-1:0]        test_value,
  output logic [tdpg_pkg::PRIME_W-1:0]       prime_value,
  output logic [tdpg_pkg::INDEX_W-1:0]       prime_index,
  output logic                               is_prime,
  output logic                               last
);
  import tdpg_pkg::*;

  localparam int CW = $clog2(MAX_PRIMES + 1);
  localparam int AW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;

  logic [PRIME_W-1:0]   prime_mem [MAX_PRIMES];
  logic [PRIME_W-1:0]   rdata;
  logic [PRIME_W-1:0]   p;
  logic [PRIME_W-1:0]   rem;
  logic [PRIME_W-1:0]   rem_next;
  logic [PRIME_W:0]     trial;
  logic [2*PRIME_W-1:0] sq;
  logic [VALUE_W-1:0]   v;
  logic [VALUE_W-1:0]   dvd;
  logic [BITCNT_W-1:0]  bitcnt;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        k;
  logic [CW-1:0]        target;
  logic [CW-1:0]        cnt_sat;
  logic                 req_test;
  logic                 gen_last;

  always_comb begin
    if (prime_count == '0) begin
      cnt_sat = CW'(1);
    end else if (32'(prime_count) > 32'(MAX_PRIMES)) begin
      cnt_sat = CW'(MAX_PRIMES);
    end else begin
      cnt_sat = CW'(prime_count);
    end
  end

  assign trial    = {rem, dvd[VALUE_W-1]};
  assign rem_next = (trial >= {1'b0, p}) ? PRIME_W'(trial - {1'b0, p})
                                         : trial[PRIME_W-1:0];
  assign gen_last = ((fill + CW'(1)) == target);

  assign status.is_test   = req_test;
  assign status.below_two = (v[VALUE_W-1:1] == '0);
  assign status.k_at_fill = (k >= fill);
  assign status.sq_gt     = (sq > {2'b00, v});
  assign status.div_last  = (bitcnt == '0);
  assign status.rem_zero  = (rem == '0);
  assign status.gen_last  = gen_last;

  always_ff @(posedge clk) begin
    if (cmd.emit && !req_test) begin
      prime_mem[fill[AW-1:0]] <= v[PRIME_W-1:0];
    end
    if (cmd.rd) begin
      rdata <= prime_mem[k[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.load && req_type == REQ_GENERATE) begin
      fill <= '0;
    end else if (cmd.emit && !req_test) begin
      fill <= fill + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_test <= (req_type == REQ_TEST);
      target   <= cnt_sat;
      k        <= '0;
      v        <= (req_type == REQ_TEST) ? test_value : VALUE_W'(2);
    end
    if (cmd.k_inc) begin
      k <= k + CW'(1);
    end
    if (cmd.cand_inc) begin
      v <= v + VALUE_W'(1);
      k <= '0;
    end
    if (cmd.sq_load) begin
      p  <= rdata;
      sq <= rdata * rdata;
    end
    if (cmd.div_start) begin
      rem    <= '0;
      dvd    <= v;
      bitcnt <= BITCNT_W'(VALUE_W - 1);
    end
    if (cmd.div_step) begin
      rem    <= rem_next;
      dvd    <= {dvd[VALUE_W-2:0], 1'b0};
      bitcnt <= bitcnt - BITCNT_W'(1);
    end
    if (cmd.emit) begin
      if (req_test) begin
        prime_value <= '0;
        prime_index <= '0;
        is_prime    <= cmd.answer;
        last        <= 1'b1;
      end else begin
        prime_value <= v[PRIME_W-1:0];
        prime_index <= INDEX_W'(fill);
        is_prime    <= 1'b1;
        last        <= gen_last;
        v           <= v + VALUE_W'(1);
        k           <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### sv/trial_division_prime_generator.sv
// Channel   Direction  Words
// s_axis    in         one request: generate the first N primes or test one value
// m_axis    out        one word per prime found, or one test answer; tlast ends a request
//
// Each trial divisor takes a table read, a registered square, a compare, the remainder
// unit working through all sixteen dividend bits at one dividend bit per cycle, and a check.
// Generating 64 primes takes some seven hundred trial divisions; a test divides by the
// stored primes in turn. One request is worked on at a time; a word waiting on m_axis
// stalls the search once the next word is ready. Reset empties the table.
`default_nettype none
module trial_division_prime_generator #(
  parameter int MAX_PRIMES = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // prime_count[6:0], test_value[22:7], zero[23]
  input  wire         s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // prime_value[8:0], prime_index[14:9], is_prime[15]
  output logic        m_axis_tlast
);
  import tdpg_pkg::*;

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [PRIME_W-1:0]   prime_value;
  logic [INDEX_W-1:0]   prime_index;
  logic                 is_prime;

  tdpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  tdpg_dp #(
    .MAX_PRIMES (MAX_PRIMES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .req_type    (s_axis_tuser),
    .prime_count (s_axis_tdata[COUNT_W-1:0]),
    .test_value  (s_axis_tdata[COUNT_W+VALUE_W-1:COUNT_W]),
    .prime_value (prime_value),
    .prime_index (prime_index),
    .is_prime    (is_prime),
    .last        (m_axis_tlast)
  );

  assign m_axis_tdata = {is_prime, prime_index, prime_value};

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  a_odd_prime: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[8:0] != 9'd0 && m_axis_tdata[8:0] != 9'd2
      |-> m_axis_tdata[0] && m_axis_tdata[15])
    else $error("generated prime is even or not marked prime");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 32'(m_axis_tdata[14:9]) < 32'(MAX_PRIMES))
    else $error("prime index beyond table depth");

endmodule
`default_nettype wire
